[src/spq_pkg.sv]
package spq_pkg;

  localparam int ValueWidth = 32;
  localparam int PrioWidth  = 8;
  localparam int OccWidth   = 5;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                         func;
    logic signed [ValueWidth-1:0] item_value;
    logic [PrioWidth-1:0]         item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [ValueWidth-1:0] out_value;
    logic [PrioWidth-1:0]         out_priority;
    logic [OccWidth-1:0]          occupancy;
  } spq_out_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [PrioWidth-1:0]         prio;
  } spq_entry_t;

endpackage

[src/spq_mem.sv]
module spq_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  spq_pkg::spq_entry_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output spq_pkg::spq_entry_t rdata_o
);
  import spq_pkg::*;

  spq_entry_t mem_q [DEPTH];
  spq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/spq_ctrl.sv]
module spq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spq_pkg::spq_in_t    in_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output spq_pkg::spq_out_t   res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output spq_pkg::spq_entry_t mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  spq_pkg::spq_entry_t mem_rdata_i
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PUT,
    S_DEQ_RD0,
    S_DEQ_HEAD,
    S_DEQ_RD,
    S_DEQ_MV
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  spq_entry_t    item_q, item_d;
  logic [1:0]    status_q, status_d;
  spq_entry_t    head_q, head_d;

  logic fin_enq, fin_deq;

  always_comb begin
    state_d  = state_q;
    done_d   = done_q;
    pos_d    = pos_q;
    count_d  = count_q;
    item_d   = item_q;
    status_d = status_q;
    head_d   = head_q;
    fin_enq  = 1'b0;
    fin_deq  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = item_q;
    mem_raddr_o = pos_q;

    if (done_q) begin
      if (res_ready_i) begin
        done_d = 1'b0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_d.value = in_i.item_value;
            item_d.prio  = in_i.item_priority;
            status_d = ST_OK;
            head_d   = '0;
            pos_d    = count_q[AW-1:0];
            if (in_i.func == FUNC_ENQ) begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_OVERFLOW;
                done_d   = 1'b1;
              end else if (count_q == '0) begin
                state_d = S_ENQ_PUT;
              end else begin
                state_d = S_ENQ_RD;
              end
            end else begin
              pos_d = '0;
              if (count_q == '0) begin
                status_d = ST_UNDERFLOW;
                done_d   = 1'b1;
              end else begin
                state_d = S_DEQ_RD0;
              end
            end
          end
        end
        S_ENQ_RD: begin
          mem_raddr_o = pos_q - AW'(1);
          state_d     = S_ENQ_CMP;
        end
        S_ENQ_CMP: begin
          mem_we_o = 1'b1;
          if (mem_rdata_i.prio < item_q.prio) begin
            mem_wdata_o = mem_rdata_i;
            pos_d       = pos_q - AW'(1);
            state_d     = (pos_q == AW'(1)) ? S_ENQ_PUT : S_ENQ_RD;
          end else begin
            fin_enq = 1'b1;
          end
        end
        S_ENQ_PUT: begin
          mem_we_o = 1'b1;
          fin_enq  = 1'b1;
        end
        S_DEQ_RD0: begin
          mem_raddr_o = '0;
          state_d     = S_DEQ_HEAD;
        end
        S_DEQ_HEAD: begin
          head_d = mem_rdata_i;
          if (count_q == CW'(1)) begin
            fin_deq = 1'b1;
          end else begin
            state_d = S_DEQ_RD;
          end
        end
        S_DEQ_RD: begin
          mem_raddr_o = pos_q + AW'(1);
          state_d     = S_DEQ_MV;
        end
        S_DEQ_MV: begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          pos_d       = pos_q + AW'(1);
          if (CW'(pos_q) + CW'(2) == count_q) begin
            fin_deq = 1'b1;
          end else begin
            state_d = S_DEQ_RD;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end

    if (fin_enq) begin
      count_d = count_q + CW'(1);
      state_d = S_IDLE;
      done_d  = 1'b1;
    end
    if (fin_deq) begin
      count_d = count_q - CW'(1);
      state_d = S_IDLE;
      done_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      pos_q    <= '0;
      count_q  <= '0;
      item_q   <= '0;
      status_q <= ST_OK;
      head_q   <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      pos_q    <= pos_d;
      count_q  <= count_d;
      item_q   <= item_d;
      status_q <= status_d;
      head_q   <= head_d;
    end
  end

  assign in_ready_o         = (state_q == S_IDLE) && !done_q;
  assign res_valid_o        = done_q;
  assign res_o.status       = status_q;
  assign res_o.out_value    = head_q.value;
  assign res_o.out_priority = head_q.prio;
  assign res_o.occupancy    = OccWidth'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == ST_OVERFLOW |-> count_q == CW'(DEPTH))
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q == ST_UNDERFLOW |-> count_q == '0)
    else $error("underflow reported while not empty");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || done_q) |-> !mem_we_o)
    else $error("store written outside an operation");

endmodule

[src/sorted_priority_queue_top.sv]
// Sorted priority queue, highest priority at the head.
// Input channel (in_valid_i/in_ready_o/in_i): one word is one operation,
// enqueue of a value and priority, or dequeue of the head. An enqueued entry
// goes behind all entries of greater or equal priority.
// Output channel (out_valid_o/out_ready_i/out_o): one result word per
// operation with status, dequeued value/priority and occupancy after it.
// Operations run one at a time on a store with one read and one write port,
// walked by a sequencer with one priority comparator; every step of the walk
// is a read followed by a compare/write (enqueue) or a move (dequeue).
// Overflow and underflow are reported without a walk of the store.
// The next word is taken only after the result has entered the output
// register. The output register lets a result wait while the next operation
// runs; a stalled receiver holds the sequencer only when a second result is
// ready before the first is taken.
// Reset empties the queue; store contents are not cleared.
module sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_o
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic          res_valid, res_ready;
  spq_out_t      res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  spq_entry_t    mem_wdata, mem_rdata;

  logic     out_valid_q, out_valid_d;
  spq_out_t out_q, out_d;

  spq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  spq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[tb/tb_sorted_priority_queue_top.sv]
module tb_sorted_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int Depth      = 16;
  localparam int CycleLimit = 1000000;
  localparam int MaxPrinted = 50;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_i        = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_o;

  sorted_priority_queue_top #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected queue contents, head at index 0.
  logic signed [ValueWidth-1:0] held_value [Depth];
  logic [PrioWidth-1:0]         held_prio  [Depth];
  int                           held_count = 0;

  spq_out_t awaited_results [$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  // Receiver control: random stall rate plus a long hold-off on request.
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_len       = 0;
  int   hold_left      = 0;

  function automatic spq_out_t apply_queue_op(input spq_in_t w);
    spq_out_t r;
    int       pos;
    int       k;
    r = '0;
    r.status = ST_OK;
    if (w.func == FUNC_ENQ) begin
      if (held_count >= Depth) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] < w.item_priority) begin
          held_value[pos] = held_value[pos-1];
          held_prio[pos]  = held_prio[pos-1];
          pos--;
        end
        held_value[pos] = w.item_value;
        held_prio[pos]  = w.item_priority;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.out_value    = held_value[0];
        r.out_priority = held_prio[0];
        for (k = 0; k + 1 < held_count; k++) begin
          held_value[k] = held_value[k+1];
          held_prio[k]  = held_prio[k+1];
        end
        held_count--;
      end
    end
    r.occupancy = OccWidth'(held_count);
    return r;
  endfunction

  function automatic spq_in_t enq_word(input logic [ValueWidth-1:0] v,
                                       input logic [PrioWidth-1:0] p);
    spq_in_t w;
    w.func          = FUNC_ENQ;
    w.item_value    = v;
    w.item_priority = p;
    return w;
  endfunction

  // Unused fields of a dequeue carry random bits.
  function automatic spq_in_t deq_word();
    spq_in_t w;
    w.func          = FUNC_DEQ;
    w.item_value    = $urandom;
    w.item_priority = PrioWidth'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic logic [PrioWidth-1:0] rand_prio();
    logic [PrioWidth-1:0] p;
    case ($urandom_range(0, 3))
      0: begin
        p = PrioWidth'($urandom_range(0, 255));
      end
      1: begin
        p = PrioWidth'($urandom_range(0, 3));
      end
      2: begin
        p = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      default: begin
        p = PrioWidth'($urandom_range(100, 103));
      end
    endcase
    return p;
  endfunction

  function automatic logic [ValueWidth-1:0] rand_value();
    logic [ValueWidth-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    if (mismatch_count < MaxPrinted) begin
      $display("ERROR cycle %0d %s: got %0h expected %0h", cycle_count, what, got, exp);
    end
    mismatch_count++;
  endtask

  // Called just after the rising clock. Leaves valid high after acceptance.
  task automatic send_op(input spq_in_t w);
    in_i       <= w;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_results.push_back(apply_queue_op(w));
  endtask

  task automatic idle_sender(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic hold_receiver(input int n);
    hold_len <= n;
    hold_req <= ~hold_req;
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    spq_out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word", 64'(out_o), 64'd0);
      end else begin
        exp = awaited_results.pop_front();
        if (out_o.status !== exp.status)
          report_mismatch("status", 64'(out_o.status), 64'(exp.status));
        if (out_o.out_value !== exp.out_value)
          report_mismatch("out_value", 64'(out_o.out_value), 64'(exp.out_value));
        if (out_o.out_priority !== exp.out_priority)
          report_mismatch("out_priority", 64'(out_o.out_priority), 64'(exp.out_priority));
        if (out_o.occupancy !== exp.occupancy)
          report_mismatch("occupancy", 64'(out_o.occupancy), 64'(exp.occupancy));
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sorted_priority_queue_top: mismatch");
    $finish;
  end

  task automatic test_underflow_on_empty();
    send_op(deq_word());
    send_op(deq_word());
    pause_until_drained();
  endtask

  task automatic test_extreme_fields();
    send_op(enq_word(32'h8000_0000, 8'h00));
    send_op(enq_word(32'h7fff_ffff, 8'hff));
    send_op(enq_word(32'h0000_0000, 8'h80));
    send_op(enq_word(32'hffff_ffff, 8'hff));
    send_op(enq_word(32'h5555_aaaa, 8'h00));
    repeat (5) send_op(deq_word());
    send_op(deq_word());
    pause_until_drained();
  endtask

  task automatic test_equal_priority_order();
    send_op(enq_word(32'd1, 8'd5));
    idle_sender(1);
    send_op(enq_word(32'd2, 8'd5));
    send_op(enq_word(32'd3, 8'd9));
    idle_sender(3);
    send_op(enq_word(32'd4, 8'd5));
    repeat (4) send_op(deq_word());
    pause_until_drained();
  endtask

  // Receiver held off while the sender keeps offering; fills and overflows.
  task automatic test_backpressure();
    recv_stall_pct <= 0;
    hold_receiver(400);
    repeat (Depth + 4) send_op(enq_word(rand_value(), rand_prio()));
    pause_until_drained();
    hold_receiver(200);
    repeat (Depth + 1) begin
      send_op(deq_word());
      if ($urandom_range(0, 1)) idle_sender($urandom_range(1, 3));
    end
    pause_until_drained();
  endtask

  task automatic test_random_ops(input int n, input int send_idle_pct,
                                 input int recv_pct);
    int enq_pct;
    recv_stall_pct <= recv_pct;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      // Drift the enqueue share so occupancy sweeps empty to full.
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < send_idle_pct) idle_sender($urandom_range(1, 6));
      if ($urandom_range(0, 99) < enq_pct) begin
        send_op(enq_word(rand_value(), rand_prio()));
      end else begin
        send_op(deq_word());
      end
    end
    pause_until_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_underflow_on_empty();
    test_extreme_fields();
    test_equal_priority_order();
    test_backpressure();
    test_random_ops(400, 0, 0);
    test_random_ops(400, 52, 0);
    test_random_ops(400, 0, 52);
    test_random_ops(400, 12, 12);

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("sorted_priority_queue_top: match");
    end else begin
      $display("sorted_priority_queue_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
src/spq_pkg.sv
src/spq_mem.sv
src/spq_ctrl.sv
src/sorted_priority_queue_top.sv
tb/tb_sorted_priority_queue_top.sv
